@@ rtl/core/smbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbm_pkg
// Shared types, widths and register codes of the two-rule byte signature
// matcher.
// ----------------------------------------------------------------------------
package smbm_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int NUM_RULES         = 2;
	localparam int POS_W             = $clog2(MAX_PATTERN_BYTES);
	localparam int LEN_W             = 5;
	localparam int HALF_W            = 64;
	localparam int PAT_W             = 2 * HALF_W;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_R0_PAT_LO = 3'd0,
		REG_R0_PAT_HI = 3'd1,
		REG_R0_LENGTH = 3'd2,
		REG_R1_PAT_LO = 3'd3,
		REG_R1_PAT_HI = 3'd4,
		REG_R1_LENGTH = 3'd5
	} cfg_reg_t;

	localparam logic [HALF_W-1:0] R0_PAT_LO_RST = 64'h4140_2550_214F_3558;
	localparam logic [HALF_W-1:0] R0_PAT_HI_RST = 64'h0000_0000_0000_0050;
	localparam logic [LEN_W-1:0]  R0_LEN_RST    = 5'd9;
	localparam logic [HALF_W-1:0] R1_PAT_LO_RST = 64'h0000_00EC_8B55_E4FF;
	localparam logic [HALF_W-1:0] R1_PAT_HI_RST = 64'h0000_0000_0000_0000;
	localparam logic [LEN_W-1:0]  R1_LEN_RST    = 5'd5;

	typedef struct packed {
		logic [PAT_W-1:0] pattern;
		logic [LEN_W-1:0] length;
	} rule_cfg_t;

	typedef logic [NUM_RULES-1:0] match_t;

	typedef struct packed {
		logic verdict;
		logic rule_index;
	} result_t;

endpackage

@@ rtl/core/smbm_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbm_byte_if
// Byte request channel: one buffer byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface smbm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/smbm_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbm_result_if
// Result channel: scan verdict and lowest matching rule.
// ----------------------------------------------------------------------------
interface smbm_result_if;
	logic valid;
	logic ready;
	logic verdict;
	logic rule_index;

	modport source (output valid, output verdict, output rule_index, input ready);
	modport sink   (input valid, input verdict, input rule_index, output ready);
endinterface

@@ rtl/core/smbm_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface smbm_cfg_if;
	import smbm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/core/smbm_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbm_cfg_regs
// Rule pattern and length registers, written through the config channel.
// ----------------------------------------------------------------------------
module smbm_cfg_regs (
	input  logic                                            clk,
	input  logic                                            arst_n,
	smbm_cfg_if.sink                                        cfg,
	output smbm_pkg::rule_cfg_t [smbm_pkg::NUM_RULES-1:0]  rules
);
	import smbm_pkg::*;

	logic [HALF_W-1:0] r0_lo_q, r0_hi_q, r1_lo_q, r1_hi_q;
	logic [LEN_W-1:0]  r0_len_q, r1_len_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_lo_q  <= R0_PAT_LO_RST;
			r0_hi_q  <= R0_PAT_HI_RST;
			r0_len_q <= R0_LEN_RST;
			r1_lo_q  <= R1_PAT_LO_RST;
			r1_hi_q  <= R1_PAT_HI_RST;
			r1_len_q <= R1_LEN_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.reg_index))
				REG_R0_PAT_LO: r0_lo_q  <= cfg.wr_data;
				REG_R0_PAT_HI: r0_hi_q  <= cfg.wr_data;
				REG_R0_LENGTH: r0_len_q <= cfg.wr_data[LEN_W-1:0];
				REG_R1_PAT_LO: r1_lo_q  <= cfg.wr_data;
				REG_R1_PAT_HI: r1_hi_q  <= cfg.wr_data;
				REG_R1_LENGTH: r1_len_q <= cfg.wr_data[LEN_W-1:0];
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	assign rules[0] = '{pattern: {r0_hi_q, r0_lo_q}, length: r0_len_q};
	assign rules[1] = '{pattern: {r1_hi_q, r1_lo_q}, length: r1_len_q};

endmodule

@@ rtl/core/smbm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbm_cell
// One window position: holds a byte and its fill bit, compares the byte
// arriving from its neighbor against the rule byte due at this position,
// and extends the match chain.
// ----------------------------------------------------------------------------
module smbm_cell (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            shift_en,
	input  logic                                            clear_en,
	input  logic [smbm_pkg::POS_W-1:0]                      pos,
	input  logic [7:0]                                      byte_in,
	input  logic                                            valid_in,
	input  smbm_pkg::rule_cfg_t [smbm_pkg::NUM_RULES-1:0]  rules,
	input  smbm_pkg::match_t                                match_in,
	output smbm_pkg::match_t                                match_out,
	output logic [7:0]                                      byte_out,
	output logic                                            valid_out
);
	import smbm_pkg::*;

	logic [7:0] byte_q;
	logic       valid_q;

	always_comb begin
		logic [LEN_W-1:0] pos_ext;
		logic             needed;
		logic [POS_W-1:0] idx;
		logic [7:0]       expect_byte;
		pos_ext   = LEN_W'(pos);
		match_out = match_in;
		for (int r = 0; r < NUM_RULES; r++) begin
			// pattern byte k sits at window entry length-1-k
			needed      = pos_ext < rules[r].length;
			idx         = POS_W'(rules[r].length - LEN_W'(1) - pos_ext);
			expect_byte = rules[r].pattern[idx*8 +: 8];
			if (needed && !(valid_in && (byte_in == expect_byte)))
				match_out[r] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= valid_in && !clear_en;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out  = byte_q;
	assign valid_out = valid_q;

endmodule

@@ rtl/core/two_rule_byte_signature_matcher_unit.sv @@
`timescale 1ns / 1ps
// A buffer's result is registered into the result queue when its last byte is accepted.
// Throughput: one byte per cycle while the skid entry is empty; the window cells compare
// the incoming byte in parallel. A two-entry result queue lets bytes keep flowing while
// a result waits to be taken. Reset clears window fill bits, hit flags and the result
// queue; rules load the stock signatures.
// ----------------------------------------------------------------------------
// two_rule_byte_signature_matcher_unit
// Shift window of identical cells matching two configurable byte patterns.
// ----------------------------------------------------------------------------
module two_rule_byte_signature_matcher_unit (
	input  logic          clk,
	input  logic          arst_n,
	smbm_byte_if.sink     byte_req,
	smbm_result_if.source result,
	smbm_cfg_if.sink      cfg
);
	import smbm_pkg::*;

	rule_cfg_t [NUM_RULES-1:0] rules;
	match_t    [MAX_PATTERN_BYTES:0] chain;
	logic      [MAX_PATTERN_BYTES:0][7:0] win_byte;
	logic      [MAX_PATTERN_BYTES:0] win_valid;

	match_t  flags_q, rule_en, hit, flags_nxt;
	result_t res, out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    in_acc, push, pop;

	smbm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rules  (rules)
	);

	assign in_acc      = byte_req.valid && byte_req.ready;
	assign chain[0]    = '1;
	assign win_byte[0] = byte_req.data_byte;
	assign win_valid[0] = 1'b1;

	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
		smbm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (in_acc),
			.clear_en  (byte_req.last_byte),
			.pos       (POS_W'(i)),
			.byte_in   (win_byte[i]),
			.valid_in  (win_valid[i]),
			.rules     (rules),
			.match_in  (chain[i]),
			.match_out (chain[i+1]),
			.byte_out  (win_byte[i+1]),
			.valid_out (win_valid[i+1])
		);
	end

	always_comb begin
		for (int r = 0; r < NUM_RULES; r++)
			rule_en[r] = (rules[r].length != '0) &&
				(rules[r].length <= LEN_W'(MAX_PATTERN_BYTES));
		hit            = rule_en & chain[MAX_PATTERN_BYTES];
		flags_nxt      = flags_q | hit;
		res.verdict    = |flags_nxt;
		res.rule_index = (|flags_nxt) && !flags_nxt[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (in_acc) begin
			flags_q <= byte_req.last_byte ? '0 : flags_nxt;
		end
	end

	// result queue: output register plus one skid entry
	assign push           = in_acc && byte_req.last_byte;
	assign pop            = out_valid_q && result.ready;
	assign byte_req.ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push)
					skid_q <= res;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.verdict    = out_q.verdict;
	assign result.rule_index = out_q.rule_index;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !byte_req.last_byte && !out_valid_q) |=> !out_valid_q)
		else $error("result produced without a last byte");

	a_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (flags_q == '0) && (win_valid[1] == 1'b0))
		else $error("scan state not cleared after last byte");

	a_clean_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.verdict) |-> !out_q.rule_index)
		else $error("clean verdict with nonzero rule index");

endmodule

@@ tb/smbm_scan_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbm_scan_checker
// Watches the byte, result and configuration channels of the signature
// matcher. Keeps its own copy of the rule registers, the byte window, the
// fill count and the hit flags, works out the verdict of every buffer and
// compares each returned verdict with the oldest one still owed.
// ----------------------------------------------------------------------------
module smbm_scan_checker
	import smbm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	smbm_byte_if   byte_mon,
	smbm_result_if result_mon,
	smbm_cfg_if    cfg_mon,
	output int     fail_count,
	output int     pending,
	output int     n_verdicts,
	output int     n_malware
);

	logic [7:0]       window [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0] fill;
	match_t           hits;
	rule_cfg_t        rules [NUM_RULES];
	result_t          verdicts_due [$];
	int               misses;
	int               checked;
	int               flagged;

	function automatic logic rule_hit(input int r);
		int n;
		n = int'(rules[r].length);
		if (n == 0 || n > MAX_PATTERN_BYTES || int'(fill) < n)
			return 1'b0;
		// pattern byte 0 is the oldest of the newest n bytes
		for (int k = 0; k < n; k++)
			if (window[n-1-k] != rules[r].pattern[8*k +: 8])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void clear_scan();
		foreach (window[i])
			window[i] = '0;
		fill = '0;
		hits = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		result_t got;
		if (!arst_n) begin
			rules[0].pattern = {R0_PAT_HI_RST, R0_PAT_LO_RST};
			rules[0].length  = R0_LEN_RST;
			rules[1].pattern = {R1_PAT_HI_RST, R1_PAT_LO_RST};
			rules[1].length  = R1_LEN_RST;
			clear_scan();
			verdicts_due.delete();
			misses  = 0;
			checked = 0;
			flagged = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.reg_index)
					REG_R0_PAT_LO: rules[0].pattern[HALF_W-1:0]     = cfg_mon.wr_data;
					REG_R0_PAT_HI: rules[0].pattern[PAT_W-1:HALF_W] = cfg_mon.wr_data;
					REG_R0_LENGTH: rules[0].length = cfg_mon.wr_data[LEN_W-1:0];
					REG_R1_PAT_LO: rules[1].pattern[HALF_W-1:0]     = cfg_mon.wr_data;
					REG_R1_PAT_HI: rules[1].pattern[PAT_W-1:HALF_W] = cfg_mon.wr_data;
					REG_R1_LENGTH: rules[1].length = cfg_mon.wr_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (byte_mon.valid && byte_mon.ready) begin
				for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
					window[i] = window[i-1];
				window[0] = byte_mon.data_byte;
				if (fill < MAX_PATTERN_BYTES)
					fill++;
				for (int r = 0; r < NUM_RULES; r++)
					if (rule_hit(r))
						hits[r] = 1'b1;
				if (byte_mon.last_byte) begin
					want.verdict    = |hits;
					want.rule_index = hits[1] & ~hits[0];
					verdicts_due.push_back(want);
					clear_scan();
				end
			end
			if (result_mon.valid && result_mon.ready) begin
				got.verdict    = result_mon.verdict;
				got.rule_index = result_mon.rule_index;
				if (verdicts_due.size() == 0) begin
					misses++;
					$display("%t: verdict with no buffer outstanding: expected none, actual %0b/%0b",
						$time, got.verdict, got.rule_index);
				end else begin
					want = verdicts_due.pop_front();
					checked++;
					if (want.verdict)
						flagged++;
					if (got.verdict !== want.verdict) begin
						misses++;
						$display("%t: verdict mismatch: expected %0b actual %0b",
							$time, want.verdict, got.verdict);
					end
					if (got.rule_index !== want.rule_index) begin
						misses++;
						$display("%t: rule_index mismatch: expected %0b actual %0b",
							$time, want.rule_index, got.rule_index);
					end
				end
			end
		end
		fail_count <= misses;
		pending    <= verdicts_due.size();
		n_verdicts <= checked;
		n_malware  <= flagged;
	end

endmodule

@@ tb/tb_two_rule_byte_signature_matcher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_rule_byte_signature_matcher_unit
// Streams buffers through the signature matcher under a series of rule
// settings: stock signatures, widest and narrowest rules, zero and overlong
// lengths, all-zero and all-one patterns, then random rules. Buffers carry
// planted and spoiled copies of the rule patterns; both sides stall at random.
// ----------------------------------------------------------------------------
module tb_two_rule_byte_signature_matcher_unit;
	import smbm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 1000;
	localparam int IDLE_PCT      = 19;

	typedef logic [7:0] byte_q_t [$];

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic jitter = 1'b1;
	int   quiet  = 0;
	int   bytes_sent   = 0;
	int   buffers_sent = 0;
	int   settings     = 1;
	int   fail_count;
	int   verdicts_pending;
	int   n_verdicts;
	int   n_malware;

	logic [PAT_W-1:0] plant_pat [NUM_RULES];
	logic [LEN_W-1:0] plant_len [NUM_RULES];

	smbm_byte_if   byte_req ();
	smbm_result_if result ();
	smbm_cfg_if    cfg ();

	two_rule_byte_signature_matcher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_req (byte_req),
		.result   (result),
		.cfg      (cfg)
	);

	smbm_scan_checker scan_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_mon   (byte_req),
		.result_mon (result),
		.cfg_mon    (cfg),
		.fail_count (fail_count),
		.pending    (verdicts_pending),
		.n_verdicts (n_verdicts),
		.n_malware  (n_malware)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((byte_req.valid && byte_req.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%t: no traffic for %0d cycles", $time, QUIET_LIMIT);
			$display("two_rule_byte_signature_matcher_unit regression: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic byte_q_t rule_bytes(input int r, input int n);
		byte_q_t q;
		for (int k = 0; k < n; k++)
			q.push_back(plant_pat[r][8*k +: 8]);
		return q;
	endfunction

	function automatic logic [PAT_W-1:0] rand_pat();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick < 3)
			return LEN_W'($urandom_range(31, 17));
		return LEN_W'($urandom_range(16, 1));
	endfunction

	task automatic send_buffer(input byte_q_t q);
		foreach (q[i]) begin
			while (jitter && $urandom_range(99) < IDLE_PCT) begin
				byte_req.valid <= 1'b0;
				@(posedge clk);
			end
			byte_req.valid     <= 1'b1;
			byte_req.data_byte <= q[i];
			byte_req.last_byte <= (i == q.size() - 1);
			@(posedge clk);
			while (!byte_req.ready)
				@(posedge clk);
		end
		bytes_sent += q.size();
		buffers_sent++;
	endtask

	// drop valid and hold until every verdict is back and the block is quiet
	task automatic settle();
		byte_req.valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_rules(input logic [PAT_W-1:0] p0, input logic [LEN_W-1:0] l0,
			input logic [PAT_W-1:0] p1, input logic [LEN_W-1:0] l1);
		logic [CFG_IDX_W-1:0]  idx [7];
		logic [CFG_DATA_W-1:0] val [7];
		idx = '{REG_R0_PAT_LO, REG_R0_PAT_HI, REG_R0_LENGTH,
			REG_R1_PAT_LO, REG_R1_PAT_HI, REG_R1_LENGTH, REG_SPARE_LO};
		if ($urandom_range(1))
			idx[6] = REG_SPARE_HI;
		// length words keep random upper bits; the spare index write must be dropped
		foreach (val[i])
			val[i] = {$urandom, $urandom};
		val[0] = p0[HALF_W-1:0];
		val[1] = p0[PAT_W-1:HALF_W];
		val[2][LEN_W-1:0] = l0;
		val[3] = p1[HALF_W-1:0];
		val[4] = p1[PAT_W-1:HALF_W];
		val[5][LEN_W-1:0] = l1;
		foreach (idx[i]) begin
			cfg.valid     <= 1'b1;
			cfg.reg_index <= idx[i];
			cfg.wr_data   <= val[i];
			@(posedge clk);
			while (!cfg.ready)
				@(posedge clk);
		end
		cfg.valid <= 1'b0;
		plant_pat[0] = p0;
		plant_len[0] = l0;
		plant_pat[1] = p1;
		plant_len[1] = l1;
		settings++;
	endtask

	task automatic run_phase(input int n_bytes);
		byte_q_t buf_q;
		byte_q_t seg;
		int      target;
		int      n;
		int      r;
		int      eff;
		int      at;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			buf_q.delete();
			n = ($urandom_range(99) < 80) ? $urandom_range(24, 1) : $urandom_range(48, 25);
			// half the filler comes from the pattern bytes to raise partial matches
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(1)) begin
					buf_q.push_back(8'($urandom));
				end else begin
					r = $urandom_range(NUM_RULES - 1);
					buf_q.push_back(plant_pat[r][8*$urandom_range(15) +: 8]);
				end
			end
			repeat ($urandom_range(2)) begin
				r   = $urandom_range(NUM_RULES - 1);
				eff = (plant_len[r] > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES
					: int'(plant_len[r]);
				if (eff > 0 && eff <= n) begin
					seg = rule_bytes(r, eff);
					// spoil one bit now and then for a near miss
					if ($urandom_range(3) == 0)
						seg[$urandom_range(eff - 1)] ^= 8'(1 << $urandom_range(7));
					at = $urandom_range(n - eff);
					foreach (seg[k])
						buf_q[at + k] = seg[k];
				end
			end
			send_buffer(buf_q);
		end
	endtask

	initial begin : stimulus
		byte_q_t q;
		byte_q_t seg;
		byte_req.valid     <= 1'b0;
		byte_req.data_byte <= '0;
		byte_req.last_byte <= 1'b0;
		cfg.valid          <= 1'b0;
		cfg.reg_index      <= REG_R0_PAT_LO;
		cfg.wr_data        <= '0;
		result.ready       <= 1'b0;
		plant_pat[0] = {R0_PAT_HI_RST, R0_PAT_LO_RST};
		plant_len[0] = R0_LEN_RST;
		plant_pat[1] = {R1_PAT_HI_RST, R1_PAT_LO_RST};
		plant_len[1] = R1_LEN_RST;

		fork
			forever begin
				@(posedge clk);
				result.ready <= !jitter || ($urandom_range(99) >= IDLE_PCT);
			end
		join_none

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stock signatures: both rules in one buffer, rule 0 takes priority
		q   = rule_bytes(1, 5);
		seg = rule_bytes(0, 9);
		foreach (seg[k])
			q.push_back(seg[k]);
		send_buffer(q);
		q = {8'hFF};
		send_buffer(q);
		q = {8'h00};
		send_buffer(q);
		q = rule_bytes(1, 5);
		send_buffer(q);
		// one byte short of rule 1
		q = rule_bytes(1, 4);
		send_buffer(q);
		settle();

		program_rules(rand_pat(), 5'd16, rand_pat(), 5'd1);
		run_phase(90);
		settle();

		// zero length and overlong rules never fire
		program_rules(rand_pat(), 5'd0, rand_pat(), 5'd31);
		run_phase(60);
		settle();

		// cleared window holds zeros but must not count as history
		program_rules('0, 5'd16, '0, 5'd9);
		run_phase(90);
		settle();

		program_rules('1, 5'd1, '1, 5'd16);
		run_phase(80);
		settle();

		jitter = 1'b0;
		program_rules(rand_pat(), LEN_W'($urandom_range(16, 1)),
			rand_pat(), LEN_W'($urandom_range(16, 1)));
		run_phase(150);
		settle();
		jitter = 1'b1;

		repeat (3) begin
			program_rules(rand_pat(), rand_len(), rand_pat(), rand_len());
			run_phase(50);
			settle();
		end

		$display("Scanned %0d bytes in %0d buffers under %0d rule settings.",
			bytes_sent, buffers_sent, settings);
		$display("Checked %0d verdicts, %0d of them flagged as malware.", n_verdicts, n_malware);
		if (verdicts_pending != 0)
			$display("%t: %0d verdicts never arrived", $time, verdicts_pending);
		if (fail_count == 0 && verdicts_pending == 0)
			$display("two_rule_byte_signature_matcher_unit regression: pass");
		else
			$display("two_rule_byte_signature_matcher_unit regression: fail");
		$finish;
	end

endmodule

@@ two_rule_byte_signature_matcher_unit.f @@
rtl/core/smbm_pkg.sv
rtl/core/smbm_byte_if.sv
rtl/core/smbm_result_if.sv
rtl/core/smbm_cfg_if.sv
rtl/core/smbm_cfg_regs.sv
rtl/core/smbm_cell.sv
rtl/core/two_rule_byte_signature_matcher_unit.sv
tb/smbm_scan_checker.sv
tb/tb_two_rule_byte_signature_matcher_unit.sv
